// ===== sv/lstra_pkg.sv =====
// shared types and constants for the lazy segment tree range add / range sum core
package lstra_pkg;

  localparam int unsigned MaxLeavesDef = 1024;
  localparam int unsigned CfgW         = 11;
  localparam logic [CfgW-1:0] LeafCountRst = 11'd1024;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_SUM = 1'b1
  } req_type_e;

  typedef struct packed {
    logic               req_type;
    logic [9:0]         lo;
    logic [9:0]         hi;
    logic signed [31:0] delta;
    logic               bad;
  } req_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ENTER,
    ST_COV,
    ST_PD1,
    ST_PD2,
    ST_PD3,
    ST_DL,
    ST_DR,
    ST_FIN,
    ST_CMB1,
    ST_CMB2,
    ST_RET,
    ST_DONE
  } st_e;

endpackage

// ===== sv/lstra_front.sv =====
// request intake: range check and two-entry request queue
module lstra_front #(
  parameter int unsigned CW = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [9:0]           lo_i,
  input  logic [9:0]           hi_i,
  input  logic signed [31:0]   delta_i,
  input  logic [CW-1:0]        n_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output lstra_pkg::req_t      q_data_o
);
  import lstra_pkg::*;

  req_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop, bad;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign bad        = (lo_i > hi_i) || (CW'(hi_i) >= n_i);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{req_type: req_type_i, lo: lo_i, hi: hi_i,
                            delta: delta_i, bad: bad};
    end
  end

endmodule

// ===== sv/lstra_back.sv =====
// tree walk sequencer with node sum and pending add memories, result register
module lstra_back #(
  parameter int unsigned MAX_LEAVES = lstra_pkg::MaxLeavesDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [(($clog2(MAX_LEAVES+1) > 11) ?
                 $clog2(MAX_LEAVES+1) : 11)-1:0]  n_i,
  input  logic                                    q_valid_i,
  output logic                                    q_pop_o,
  input  lstra_pkg::req_t                         q_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [31:0]                      range_total_o,
  output logic                                    bad_range_o
);
  import lstra_pkg::*;

  localparam int unsigned CW    = ($clog2(MAX_LEAVES+1) > 11) ? $clog2(MAX_LEAVES+1) : 11;
  localparam int unsigned NODES = 4 * MAX_LEAVES;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned SD    = $clog2(MAX_LEAVES) + 1;
  localparam int unsigned SPW   = $clog2(SD + 1);
  localparam int unsigned SIW   = $clog2(SD);

  logic [31:0] sum_mem  [NODES];
  logic [31:0] pend_mem [NODES];

  st_e             st_q, st_d;
  logic [NW-1:0]   clr_q;
  logic [SPW-1:0]  sp_q, spm1;
  logic            out_valid_q;
  logic [31:0]     out_total_q;
  logic            out_bad_q;

  logic [CW-1:0]   cl_q, cr_q, lo_q, hi_q;
  logic [NW-1:0]   p_q;
  logic            typ_q;
  logic [31:0]     d_q, acc_q, prod_a_q, prod_b_q, pend_q, tmp_q;
  logic [CW-1:0]   stk_cl [SD];
  logic [CW-1:0]   stk_cr [SD];
  logic [NW-1:0]   stk_p  [SD];
  logic            stk_ph [SD];

  logic            sum_we, pend_we;
  logic [NW-1:0]   sum_wa, pend_wa, sum_ra, pend_ra;
  logic [31:0]     sum_wd, pend_wd, sum_rd_q, pend_rd_q;

  logic [CW-1:0]   cm, len, len_a, len_b;
  logic [NW-1:0]   pa, pb;
  logic            covered, out_free, out_load;
  logic [31:0]     out_total_d;
  logic            out_bad_d;

  assign cm       = cl_q + ((cr_q - cl_q) >> 1);
  assign len      = cr_q - cl_q + CW'(1);
  assign len_a    = cm - cl_q + CW'(1);
  assign len_b    = cr_q - cm;
  assign pa       = {p_q[NW-2:0], 1'b0};
  assign pb       = {p_q[NW-2:0], 1'b1};
  assign covered  = (lo_q <= cl_q) && (cr_q <= hi_q);
  assign spm1     = sp_q - SPW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign range_total_o = out_total_q;
  assign bad_range_o   = out_bad_q;

  always_comb begin
    st_d        = st_q;
    q_pop_o     = 1'b0;
    sum_we      = 1'b0;
    pend_we     = 1'b0;
    sum_wa      = p_q;
    pend_wa     = p_q;
    sum_wd      = '0;
    pend_wd     = '0;
    sum_ra      = p_q;
    pend_ra     = p_q;
    out_load    = 1'b0;
    out_total_d = '0;
    out_bad_d   = 1'b0;
    unique case (st_q)
      ST_CLR: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
        sum_wa  = clr_q;
        pend_wa = clr_q;
        if (clr_q == NW'(NODES - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.bad) begin
            if (out_free) begin
              q_pop_o   = 1'b1;
              out_load  = 1'b1;
              out_bad_d = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            st_d    = ST_ENTER;
          end
        end
      end
      ST_ENTER: st_d = covered ? ST_COV : ST_PD1;
      ST_COV: begin
        if (typ_q == REQ_ADD) begin
          sum_we  = 1'b1;
          pend_we = 1'b1;
          pend_wd = pend_rd_q + d_q;
          sum_wd  = sum_rd_q + prod_a_q;
        end
        st_d = ST_RET;
      end
      ST_PD1: begin
        if ((cl_q != cr_q) && (pend_rd_q != '0)) begin
          pend_we = 1'b1;
          sum_ra  = pa;
          pend_ra = pa;
          st_d    = ST_PD2;
        end else begin
          st_d = ST_DL;
        end
      end
      ST_PD2: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
        sum_wa  = pa;
        pend_wa = pa;
        pend_wd = pend_rd_q + pend_q;
        sum_wd  = sum_rd_q + prod_a_q;
        sum_ra  = pb;
        pend_ra = pb;
        st_d    = ST_PD3;
      end
      ST_PD3: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
        sum_wa  = pb;
        pend_wa = pb;
        pend_wd = pend_rd_q + pend_q;
        sum_wd  = sum_rd_q + prod_b_q;
        st_d    = ST_DL;
      end
      ST_DL: st_d = (lo_q <= cm) ? ST_ENTER : ST_DR;
      ST_DR: st_d = (hi_q > cm) ? ST_ENTER : ST_FIN;
      ST_FIN: begin
        if (typ_q == REQ_ADD) begin
          sum_ra = pa;
          st_d   = ST_CMB1;
        end else begin
          st_d = ST_RET;
        end
      end
      ST_CMB1: begin
        sum_ra = pb;
        st_d   = ST_CMB2;
      end
      ST_CMB2: begin
        sum_we = 1'b1;
        sum_wd = tmp_q + sum_rd_q;
        st_d   = ST_RET;
      end
      ST_RET: begin
        if (sp_q == '0) st_d = ST_DONE;
        else st_d = stk_ph[spm1[SIW-1:0]] ? ST_DR : ST_FIN;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_total_d = (typ_q == REQ_ADD) ? '0 : acc_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      clr_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLR) clr_q <= clr_q + NW'(1);
      if (st_q == ST_IDLE) sp_q <= '0;
      else if (st_q == ST_DL && lo_q <= cm) sp_q <= sp_q + SPW'(1);
      else if (st_q == ST_DR && hi_q > cm) sp_q <= sp_q + SPW'(1);
      else if (st_q == ST_RET && sp_q != '0) sp_q <= spm1;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_total_q <= out_total_d;
      out_bad_q   <= out_bad_d;
    end
    case (st_q)
      ST_IDLE: begin
        if (q_pop_o) begin
          typ_q <= q_data_i.req_type;
          lo_q  <= CW'(q_data_i.lo);
          hi_q  <= CW'(q_data_i.hi);
          d_q   <= q_data_i.delta;
          cl_q  <= '0;
          cr_q  <= n_i - CW'(1);
          p_q   <= NW'(1);
          acc_q <= '0;
        end
      end
      ST_ENTER: prod_a_q <= 32'(len) * d_q;
      ST_COV: begin
        if (typ_q == REQ_SUM) acc_q <= acc_q + sum_rd_q;
      end
      ST_PD1: begin
        pend_q   <= pend_rd_q;
        prod_a_q <= pend_rd_q * 32'(len_a);
        prod_b_q <= pend_rd_q * 32'(len_b);
      end
      ST_DL: begin
        if (lo_q <= cm) begin
          stk_cl[sp_q[SIW-1:0]] <= cl_q;
          stk_cr[sp_q[SIW-1:0]] <= cr_q;
          stk_p[sp_q[SIW-1:0]]  <= p_q;
          stk_ph[sp_q[SIW-1:0]] <= 1'b1;
          cr_q <= cm;
          p_q  <= pa;
        end
      end
      ST_DR: begin
        if (hi_q > cm) begin
          stk_cl[sp_q[SIW-1:0]] <= cl_q;
          stk_cr[sp_q[SIW-1:0]] <= cr_q;
          stk_p[sp_q[SIW-1:0]]  <= p_q;
          stk_ph[sp_q[SIW-1:0]] <= 1'b0;
          cl_q <= cm + CW'(1);
          p_q  <= pb;
        end
      end
      ST_CMB1: tmp_q <= sum_rd_q;
      ST_RET: begin
        if (sp_q != '0) begin
          cl_q <= stk_cl[spm1[SIW-1:0]];
          cr_q <= stk_cr[spm1[SIW-1:0]];
          p_q  <= stk_p[spm1[SIW-1:0]];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd_q <= pend_mem[pend_ra];
  end

endmodule

// ===== sv/lazy_segment_tree_range_add_sum_core.sv =====
// top level of the lazy segment tree range add / range sum core
// after reset both node memories are cleared, 4*MAX_LEAVES entries each (4096 by default);
// up to two requests queue meanwhile, the walk starts when the pass ends
// a bad range request skips the walk with a zero total; a valid one walks down from the root,
// pushing pending adds down at split nodes; each store has one read and one write port
// only one request is in the walk at a time
module lazy_segment_tree_range_add_sum_core #(
  parameter int unsigned MAX_LEAVES = lstra_pkg::MaxLeavesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [9:0]          lo_i,
  input  logic [9:0]          hi_i,
  input  logic signed [31:0]  delta_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  range_total_o,
  output logic                bad_range_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [10:0]         cfg_data_i
);
  import lstra_pkg::*;

  localparam int unsigned CW = ($clog2(MAX_LEAVES+1) > 11) ? $clog2(MAX_LEAVES+1) : 11;

  logic [CfgW-1:0] leaf_count_q;
  logic [CW-1:0]   lc_ext, n_eff;
  logic            q_valid, q_pop;
  req_t            q_data;

  assign cfg_ready_o = 1'b1;
  assign lc_ext      = CW'(leaf_count_q);
  assign n_eff       = (leaf_count_q == '0) ? CW'(1) :
                       (lc_ext > CW'(MAX_LEAVES)) ? CW'(MAX_LEAVES) : lc_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= LeafCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      leaf_count_q <= cfg_data_i;
    end
  end

  lstra_front #(
    .CW (CW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .lo_i       (lo_i),
    .hi_i       (hi_i),
    .delta_i    (delta_i),
    .n_i        (n_eff),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  lstra_back #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_i           (n_eff),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_data_i      (q_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_total_o (range_total_o),
    .bad_range_o   (bad_range_o)
  );

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("request popped from empty queue");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_range_o) |-> (range_total_o == '0))
    else $error("flagged range with nonzero total");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (leaf_count_q == $past(cfg_data_i)))
    else $error("leaf count write lost");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the lazy segment tree range add / range sum core
`timescale 1ns / 1ps

class range_sum_board;
  bit [31:0] tree_sum[4096];
  bit [31:0] tree_pend[4096];
  bit [10:0] leaf_reg;
  bit [31:0] want_total[$];
  bit        want_bad[$];
  int        errors;

  function new();
    leaf_reg = lstra_pkg::LeafCountRst;
    errors = 0;
  endfunction

  function bit [31:0] get_sum(int unsigned p);
    return (p < 4096) ? tree_sum[p] : 32'd0;
  endfunction

  function bit [31:0] get_pend(int unsigned p);
    return (p < 4096) ? tree_pend[p] : 32'd0;
  endfunction

  function void put_sum(int unsigned p, bit [31:0] v);
    if (p < 4096) tree_sum[p] = v;
  endfunction

  function void put_pend(int unsigned p, bit [31:0] v);
    if (p < 4096) tree_pend[p] = v;
  endfunction

  function void push_pending(int unsigned cl, int unsigned cr, int unsigned p);
    int unsigned cm;
    bit [31:0]   pd;
    cm = cl + (cr - cl) / 2;
    pd = get_pend(p);
    if (cl != cr && pd != 0) begin
      put_pend(2 * p, get_pend(2 * p) + pd);
      put_pend(2 * p + 1, get_pend(2 * p + 1) + pd);
      put_sum(2 * p, get_sum(2 * p) + pd * (cm - cl + 1));
      put_sum(2 * p + 1, get_sum(2 * p + 1) + pd * (cr - cm));
      put_pend(p, 0);
    end
  endfunction

  function void range_add(int unsigned lo, int unsigned hi, bit [31:0] d,
                          int unsigned cl, int unsigned cr, int unsigned p);
    int unsigned cm;
    if (lo <= cl && cr <= hi) begin
      put_pend(p, get_pend(p) + d);
      put_sum(p, get_sum(p) + (cr - cl + 1) * d);
      return;
    end
    cm = cl + (cr - cl) / 2;
    push_pending(cl, cr, p);
    if (lo <= cm) range_add(lo, hi, d, cl, cm, 2 * p);
    if (hi > cm) range_add(lo, hi, d, cm + 1, cr, 2 * p + 1);
    put_sum(p, get_sum(2 * p) + get_sum(2 * p + 1));
  endfunction

  function bit [31:0] range_total(int unsigned lo, int unsigned hi,
                                  int unsigned cl, int unsigned cr, int unsigned p);
    int unsigned cm;
    bit [31:0]   acc;
    acc = 0;
    if (lo <= cl && cr <= hi) return get_sum(p);
    cm = cl + (cr - cl) / 2;
    push_pending(cl, cr, p);
    if (lo <= cm) acc += range_total(lo, hi, cl, cm, 2 * p);
    if (hi > cm) acc += range_total(lo, hi, cm + 1, cr, 2 * p + 1);
    return acc;
  endfunction

  function void note_request(lstra_pkg::req_type_e kind, bit [9:0] lo, bit [9:0] hi,
                             bit [31:0] d);
    int unsigned n;
    bit [31:0]   tot;
    n = leaf_reg;
    tot = 0;
    if (n == 0) n = 1;
    if (n > 1024) n = 1024;
    if (lo > hi || hi >= n) begin
      want_total.push_back(0);
      want_bad.push_back(1'b1);
      return;
    end
    if (kind == lstra_pkg::REQ_ADD) range_add(lo, hi, d, 0, n - 1, 1);
    else tot = range_total(lo, hi, 0, n - 1, 1);
    want_total.push_back(tot);
    want_bad.push_back(1'b0);
  endfunction

  function void check_result(bit [31:0] tot, bit bad);
    bit [31:0] et;
    bit        eb;
    if (want_total.size() == 0) begin
      $display("%0t: unexpected result total=%h bad=%b", $time, tot, bad);
      errors++;
      return;
    end
    et = want_total.pop_front();
    eb = want_bad.pop_front();
    if (tot !== et) begin
      $display("%0t: range_total expected %h actual %h", $time, et, tot);
      errors++;
    end
    if (bad !== eb) begin
      $display("%0t: bad_range expected %b actual %b", $time, eb, bad);
      errors++;
    end
  endfunction
endclass

module tb;
  import lstra_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = 1'b0;
  logic [9:0]         lo_i = '0;
  logic [9:0]         hi_i = '0;
  logic signed [31:0] delta_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] range_total_o;
  logic               bad_range_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [10:0]        cfg_data_i = '0;

  range_sum_board board;
  int unsigned    cycles = 0;
  int unsigned    long_hold = 0;
  bit             stall_free = 1'b0;
  int unsigned    cur_leaves = 1024;

  lazy_segment_tree_range_add_sum_core DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_result(range_total_o, bad_range_o);
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (long_hold != 0) begin
      out_stall_i <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (stall_free) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  task automatic send_req(req_type_e kind, bit [9:0] lo, bit [9:0] hi, bit [31:0] d);
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    lo_i <= lo;
    hi_i <= hi;
    delta_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(kind, lo, hi, d);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.want_total.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_leaves(bit [10:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.leaf_reg = v;
    cur_leaves = (v == 0) ? 1 : ((v > 1024) ? 1024 : v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_req();
    int unsigned a, b, lim, pick;
    req_type_e   kind;
    bit [31:0]   d;
    lim = cur_leaves;
    kind = req_type_e'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    a = $urandom_range(0, lim - 1);
    b = $urandom_range(0, lim - 1);
    if (pick == 0) begin
      a = $urandom_range(0, 1023);
      b = $urandom_range(0, 1023);
    end else if (a > b) begin
      int unsigned t;
      t = a;
      a = b;
      b = t;
    end
    case ($urandom_range(0, 3))
      0: d = $urandom();
      1: d = $urandom_range(0, 15) - 8;
      default: d = $urandom_range(0, 2000);
    endcase
    send_req(kind, 10'(a), 10'(b), d);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      int unsigned burst;
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < count) begin
          random_req();
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, both kinds, bad ranges
    send_req(REQ_ADD, 0, 1023, 32'h7fffffff);
    send_req(REQ_SUM, 0, 1023, 0);
    send_req(REQ_ADD, 1023, 1023, 32'h80000000);
    send_req(REQ_ADD, 0, 0, 32'hffffffff);
    send_req(REQ_SUM, 1023, 1023, 0);
    send_req(REQ_SUM, 0, 0, 32'hffffffff);
    send_req(REQ_ADD, 5, 4, 32'h12345678);
    send_req(REQ_SUM, 1023, 0, 0);
    send_req(REQ_ADD, 300, 700, 32'h55aa55aa);
    send_req(REQ_SUM, 511, 512, 0);
    send_req(REQ_SUM, 1, 1022, 0);
    send_req(REQ_ADD, 682, 341, 32'haaaaaaaa);
    drain();

    write_leaves(11'd1);
    send_req(REQ_SUM, 0, 0, 0);
    send_req(REQ_ADD, 0, 0, 32'd7);
    send_req(REQ_SUM, 0, 1, 0);
    send_req(REQ_SUM, 0, 0, 0);
    drain();
    write_leaves(11'd0);
    send_req(REQ_SUM, 0, 0, 0);
    drain();
    write_leaves(11'h7ff);
    send_req(REQ_SUM, 0, 1023, 0);
    drain();
    write_leaves(11'd1024);
    random_phase(400);

    // long receiver hold-off while requests keep coming
    long_hold = 600;
    random_phase(40);
    drain();

    write_leaves(11'd2);
    random_phase(200);
    drain();
    write_leaves(11'd13);
    random_phase(300);
    drain();
    write_leaves(11'd1000);
    random_phase(300);
    drain();
    write_leaves(11'd1024);
    stall_free = 1'b1;
    random_phase(150);
    stall_free = 1'b0;
    random_phase(530);

    drain();
    repeat (200) @(negedge clk_i);
    if (board.errors == 0 && board.want_total.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
